[rtl/sbr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared types, constants and the divide-by-ten helper of the 5x5 blur.
// ----------------------------------------------------------------------------
package sbr_pkg;

    localparam int CH_W          = 8;
    localparam int NUM_CH        = 3;
    localparam int NUM_TAPS      = 5;
    localparam int NUM_BANKS     = 4;
    localparam int BANK_W        = 2;
    localparam int WIDTH_REG_W   = 12;
    localparam int HEIGHT_REG_W  = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_INDEX_W   = 1;
    localparam int DIM_W         = 15;
    localparam int SUM_W         = 12;
    localparam int DIV10_MUL_W   = 11;
    localparam int DIV10_PROD_W  = SUM_W + DIV10_MUL_W;
    localparam int DIV10_SHIFT   = 14;
    localparam int KERN_SIZE     = 5;
    localparam int KERN_HALF     = 2;

    localparam logic [DIV10_MUL_W-1:0]  DIV10_MUL         = 11'd1639;
    localparam logic [WIDTH_REG_W-1:0]  FRAME_WIDTH_RST   = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] FRAME_HEIGHT_RST  = 13'd480;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef logic [CH_W-1:0] t_chan;
    typedef logic [NUM_CH-1:0][CH_W-1:0] t_pix;

    typedef struct packed {
        logic frame_end;
        t_pix pix;
    } t_result;

    // floor(s / 10) for s below 2560 via reciprocal multiply
    function automatic t_chan div10(input logic [SUM_W-1:0] s);
        logic [DIV10_PROD_W-1:0] p;
        p = DIV10_PROD_W'(s) * DIV10_PROD_W'(DIV10_MUL);
        return p[DIV10_SHIFT +: CH_W];
    endfunction

endpackage
`default_nettype wire

[rtl/sbr_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbr_lane
// One channel of the 1-2-4-2-1 kernel: weighted sum, then divide by ten.
// ----------------------------------------------------------------------------
module sbr_lane (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_en,
    input  wire logic [sbr_pkg::NUM_TAPS-1:0][sbr_pkg::CH_W-1:0] i_tap,
    output logic [sbr_pkg::CH_W-1:0]                    o_quot
);

    logic [sbr_pkg::SUM_W-1:0] r_sum;
    logic [sbr_pkg::SUM_W-1:0] n_sum;
    logic [sbr_pkg::CH_W-1:0]  r_quot;

    always_comb begin
        n_sum = sbr_pkg::SUM_W'(i_tap[0])
              + (sbr_pkg::SUM_W'(i_tap[1]) << 1)
              + (sbr_pkg::SUM_W'(i_tap[2]) << 2)
              + (sbr_pkg::SUM_W'(i_tap[3]) << 1)
              + sbr_pkg::SUM_W'(i_tap[4]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= n_sum;
            r_quot <= sbr_pkg::div10(r_sum);
        end
    end

    assign o_quot = r_quot;

endmodule
`default_nettype wire

[rtl/sbr_line_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbr_line_store
// Four line banks of horizontal results, one per row modulo four.
// All banks are read at one column; at most one bank is written per beat.
// ----------------------------------------------------------------------------
module sbr_line_store #(
    parameter  int DEPTH  = 2048,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic                           i_wr_en,
    input  wire logic [sbr_pkg::BANK_W-1:0]     i_wr_bank,
    input  wire logic [ADDR_W-1:0]              i_wr_col,
    input  wire sbr_pkg::t_pix                  i_wr_data,
    input  wire logic [ADDR_W-1:0]              i_rd_col,
    output sbr_pkg::t_pix                       o_rd_data [sbr_pkg::NUM_BANKS]
);

    for (genvar b = 0; b < sbr_pkg::NUM_BANKS; b++) begin : g_bank
        sbr_pkg::t_pix r_bank [DEPTH];
        sbr_pkg::t_pix r_rd;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (i_wr_en && (i_wr_bank == sbr_pkg::BANK_W'(b))) begin
                    r_bank[i_wr_col] <= i_wr_data;
                end
                r_rd <= r_bank[i_rd_col];
            end
        end

        assign o_rd_data[b] = r_rd;
    end

endmodule
`default_nettype wire

[rtl/sbr_out_buf.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbr_out_buf
// Output register with a skid entry; full stalls the pipeline.
// ----------------------------------------------------------------------------
module sbr_out_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire sbr_pkg::t_result i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output sbr_pkg::t_result      o_data,
    input  wire logic             i_ready
);

    logic             r_out_valid;
    logic             r_skid_valid;
    sbr_pkg::t_result r_out;
    sbr_pkg::t_result r_skid;
    logic             c_take;

    assign c_take = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (c_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !c_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (c_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (c_take) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !c_take) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

[rtl/separable_blur_5x5_rgb.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// separable_blur_5x5_rgb
// Separable 1-2-4-2-1 blur of an RGB raster stream, divide by ten per pass.
//
// Input channel i_in_valid / o_in_ready carries one pixel per beat in raster
// order; i_filler marks a flush beat. After each frame the source sends
// 2*frame_width+2 filler beats, since the result for a pixel is produced by
// the beat that many positions later. Output channel o_out_valid /
// i_out_ready carries one blurred pixel per result, o_frame_end on the last.
// Throughput is one beat per cycle while o_in_ready is high: three lanes per
// pass work side by side, and the line store bank reads and write all happen
// in one pipeline slot. After the edge that accepts a beat, its result moves
// through stage registers s1 to s6 into the output register. When the
// receiver stalls, a skid entry takes one more result and then o_in_ready
// drops until it drains. Reset restores frame_width 640 and frame_height
// 480 and restarts the position count; the line store is not cleared and
// every entry used is written earlier in the frame.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.
// ----------------------------------------------------------------------------
module separable_blur_5x5_rgb #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [sbr_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [sbr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [sbr_pkg::CH_W-1:0]           i_chan_a_in,
    input  wire logic [sbr_pkg::CH_W-1:0]           i_chan_b_in,
    input  wire logic [sbr_pkg::CH_W-1:0]           i_chan_c_in,
    input  wire logic                               i_filler,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [sbr_pkg::CH_W-1:0]                o_chan_a_out,
    output logic [sbr_pkg::CH_W-1:0]                o_chan_b_out,
    output logic [sbr_pkg::CH_W-1:0]                o_chan_c_out,
    output logic                                    o_frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int DIM_W = sbr_pkg::DIM_W;
    localparam int ROW_W = sbr_pkg::HEIGHT_REG_W;
    localparam int BK_W  = sbr_pkg::BANK_W;

    typedef struct packed {
        logic             h_act;
        logic             h_kern;
        logic [BK_W-1:0]  h_bank;
        logic [COL_W-1:0] h_col;
        logic             o_act;
        logic             o_kern;
        logic [BK_W-1:0]  o_bank;
        logic [COL_W-1:0] o_col;
        logic             last;
    } t_ctrl;

    // configuration
    logic [sbr_pkg::WIDTH_REG_W-1:0]  r_frame_width;
    logic [sbr_pkg::HEIGHT_REG_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= sbr_pkg::FRAME_WIDTH_RST;
            r_frame_height <= sbr_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sbr_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[sbr_pkg::WIDTH_REG_W-1:0];
                end
                sbr_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // effective frame size
    logic [DIM_W-1:0] c_eff_w;
    logic [ROW_W-1:0] c_eff_h;
    logic [DIM_W-1:0] c_lag;

    always_comb begin
        c_eff_w = DIM_W'(r_frame_width);
        if (c_eff_w == '0) begin
            c_eff_w = DIM_W'(1);
        end
        if (c_eff_w > DIM_W'(MAX_WIDTH)) begin
            c_eff_w = DIM_W'(MAX_WIDTH);
        end
        c_eff_h = (r_frame_height == '0) ? ROW_W'(1) : r_frame_height;
        c_lag   = (c_eff_w << 1) + DIM_W'(sbr_pkg::KERN_HALF);
    end

    // pipeline enable and input handshake
    logic c_en;
    logic c_accept;
    logic c_full;

    assign c_en       = !c_full;
    assign o_in_ready = c_en;
    assign c_accept   = i_in_valid && c_en;

    // position counters
    logic [DIM_W-1:0] r_lead,   n_lead;
    logic [COL_W-1:0] r_hcol,   n_hcol;
    logic [ROW_W-1:0] r_hrow,   n_hrow;
    logic             r_h_done, n_h_done;
    logic [COL_W-1:0] r_ocol,   n_ocol;
    logic [ROW_W-1:0] r_orow,   n_orow;

    logic             c_h_act;
    logic             c_o_act;
    logic             c_h_col_end;
    logic             c_h_row_end;
    logic             c_o_col_end;
    logic             c_o_row_end;
    t_ctrl            c_ctrl;
    sbr_pkg::t_pix    c_cur;

    always_comb begin
        c_h_act     = (r_lead >= DIM_W'(sbr_pkg::KERN_HALF)) && !r_h_done;
        c_o_act     = (r_lead >= c_lag);
        c_h_col_end = DIM_W'(r_hcol) >= (c_eff_w - DIM_W'(1));
        c_h_row_end = r_hrow >= (c_eff_h - ROW_W'(1));
        c_o_col_end = DIM_W'(r_ocol) >= (c_eff_w - DIM_W'(1));
        c_o_row_end = r_orow >= (c_eff_h - ROW_W'(1));

        c_ctrl.h_act  = c_h_act;
        c_ctrl.h_kern = (c_eff_w >= DIM_W'(sbr_pkg::KERN_SIZE))
                     && (DIM_W'(r_hcol) >= DIM_W'(sbr_pkg::KERN_HALF))
                     && (DIM_W'(r_hcol) <= c_eff_w - DIM_W'(sbr_pkg::KERN_HALF + 1));
        c_ctrl.h_bank = r_hrow[BK_W-1:0];
        c_ctrl.h_col  = r_hcol;
        c_ctrl.o_act  = c_o_act;
        c_ctrl.o_kern = (c_eff_h >= ROW_W'(sbr_pkg::KERN_SIZE))
                     && (r_orow >= ROW_W'(sbr_pkg::KERN_HALF))
                     && (r_orow <= c_eff_h - ROW_W'(sbr_pkg::KERN_HALF + 1));
        c_ctrl.o_bank = r_orow[BK_W-1:0];
        c_ctrl.o_col  = r_ocol;
        c_ctrl.last   = c_o_act && c_o_col_end && c_o_row_end;

        c_cur = i_filler ? '0 : {i_chan_c_in, i_chan_b_in, i_chan_a_in};
    end

    always_comb begin
        n_lead   = r_lead;
        n_hcol   = r_hcol;
        n_hrow   = r_hrow;
        n_h_done = r_h_done;
        n_ocol   = r_ocol;
        n_orow   = r_orow;
        if (c_accept) begin
            if (c_ctrl.last) begin
                n_lead   = '0;
                n_hcol   = '0;
                n_hrow   = '0;
                n_h_done = 1'b0;
                n_ocol   = '0;
                n_orow   = '0;
            end else begin
                if (r_lead < c_lag) begin
                    n_lead = r_lead + DIM_W'(1);
                end
                if (c_h_act) begin
                    if (c_h_col_end) begin
                        n_hcol = '0;
                        if (c_h_row_end) begin
                            n_hrow   = '0;
                            n_h_done = 1'b1;
                        end else begin
                            n_hrow = r_hrow + ROW_W'(1);
                        end
                    end else begin
                        n_hcol = r_hcol + COL_W'(1);
                    end
                end
                if (c_o_act) begin
                    if (c_o_col_end) begin
                        n_ocol = '0;
                        n_orow = r_orow + ROW_W'(1);
                    end else begin
                        n_ocol = r_ocol + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead   <= '0;
            r_hcol   <= '0;
            r_hrow   <= '0;
            r_h_done <= 1'b0;
            r_ocol   <= '0;
            r_orow   <= '0;
        end else begin
            r_lead   <= n_lead;
            r_hcol   <= n_hcol;
            r_hrow   <= n_hrow;
            r_h_done <= n_h_done;
            r_ocol   <= n_ocol;
            r_orow   <= n_orow;
        end
    end

    // pixel window, newest at tap 0
    sbr_pkg::t_pix r_tap [sbr_pkg::NUM_TAPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sbr_pkg::NUM_TAPS; i++) begin
                r_tap[i] <= '0;
            end
        end else if (c_accept) begin
            r_tap[0] <= c_cur;
            for (int i = 1; i < sbr_pkg::NUM_TAPS; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    // stage valid bits and control
    logic  r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid, r_s6_valid;
    t_ctrl r_s1_ctrl,  r_s2_ctrl,  r_s3_ctrl,  r_s4_ctrl,  r_s5_ctrl,  r_s6_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
        end else if (c_en) begin
            r_s1_valid <= c_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_s1_ctrl <= c_ctrl;
            r_s2_ctrl <= r_s1_ctrl;
            r_s3_ctrl <= r_s2_ctrl;
            r_s4_ctrl <= r_s3_ctrl;
            r_s5_ctrl <= r_s4_ctrl;
            r_s6_ctrl <= r_s5_ctrl;
        end
    end

    // horizontal lanes
    sbr_pkg::t_pix r_s2_raw, r_s3_raw;
    sbr_pkg::t_pix c_h_quot;
    sbr_pkg::t_pix c_hval;

    for (genvar ch = 0; ch < sbr_pkg::NUM_CH; ch++) begin : g_hlane
        logic [sbr_pkg::NUM_TAPS-1:0][sbr_pkg::CH_W-1:0] c_tap;
        for (genvar k = 0; k < sbr_pkg::NUM_TAPS; k++) begin : g_tap
            assign c_tap[k] = r_tap[k][ch];
        end
        sbr_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (c_en),
            .i_tap  (c_tap),
            .o_quot (c_h_quot[ch])
        );
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_s2_raw <= r_tap[sbr_pkg::KERN_HALF];
            r_s3_raw <= r_s2_raw;
        end
    end

    assign c_hval = r_s3_ctrl.h_kern ? c_h_quot : r_s3_raw;

    // line store: read-before-write in the same slot
    sbr_pkg::t_pix c_rd [sbr_pkg::NUM_BANKS];

    sbr_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_en      (c_en),
        .i_wr_en   (r_s3_valid && r_s3_ctrl.h_act),
        .i_wr_bank (r_s3_ctrl.h_bank),
        .i_wr_col  (r_s3_ctrl.h_col),
        .i_wr_data (c_hval),
        .i_rd_col  (r_s3_ctrl.o_col),
        .o_rd_data (c_rd)
    );

    sbr_pkg::t_pix r_s4_hval;

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_s4_hval <= c_hval;
        end
    end

    // vertical lanes
    sbr_pkg::t_pix   c_row_m2, c_row_m1, c_row_0, c_row_p1;
    sbr_pkg::t_pix   c_v_quot;
    sbr_pkg::t_pix   r_s5_pass, r_s6_pass;
    logic [BK_W-1:0] c_ob;

    assign c_ob     = r_s4_ctrl.o_bank;
    assign c_row_m2 = c_rd[c_ob + BK_W'(2)];
    assign c_row_m1 = c_rd[c_ob + BK_W'(3)];
    assign c_row_0  = c_rd[c_ob];
    assign c_row_p1 = c_rd[c_ob + BK_W'(1)];

    for (genvar ch = 0; ch < sbr_pkg::NUM_CH; ch++) begin : g_vlane
        logic [sbr_pkg::NUM_TAPS-1:0][sbr_pkg::CH_W-1:0] c_tap;
        assign c_tap[4] = c_row_m2[ch];
        assign c_tap[3] = c_row_m1[ch];
        assign c_tap[2] = c_row_0[ch];
        assign c_tap[1] = c_row_p1[ch];
        assign c_tap[0] = r_s4_hval[ch];
        sbr_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (c_en),
            .i_tap  (c_tap),
            .o_quot (c_v_quot[ch])
        );
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_s5_pass <= c_row_0;
            r_s6_pass <= r_s5_pass;
        end
    end

    // merge lanes into the result beat
    sbr_pkg::t_result c_result;
    sbr_pkg::t_result c_out;
    logic             c_push;

    assign c_result.pix       = r_s6_ctrl.o_kern ? c_v_quot : r_s6_pass;
    assign c_result.frame_end = r_s6_ctrl.last;
    assign c_push             = c_en && r_s6_valid && r_s6_ctrl.o_act;

    sbr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_push),
        .i_data  (c_result),
        .o_full  (c_full),
        .o_valid (o_out_valid),
        .o_data  (c_out),
        .i_ready (i_out_ready)
    );

    assign o_chan_a_out = c_out.pix[0];
    assign o_chan_b_out = c_out.pix[1];
    assign o_chan_c_out = c_out.pix[2];
    assign o_frame_end  = c_out.frame_end;

endmodule
`default_nettype wire

[tb/separable_blur_5x5_rgb_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_blur_5x5_rgb_test
// Self-checking bench for the separable 5x5 RGB blur.
//
// Complete frames are streamed through the input channel, each followed by
// its flush beats. A scoreboard tracks the raster position, the last four
// beats and four lines of horizontal results. From these it predicts every
// output pixel, including frame_end, and compares it with the block. Frame
// sizes change only between frames, once the block has drained. The run
// covers degenerate, narrow, short, wide and tall frames, fillers inside the
// frame and pixels after it, back-to-back frames, and four idle and stall
// mixes. One long receiver hold-off backs the block up to its input.
// ----------------------------------------------------------------------------
module separable_blur_5x5_rgb_test;

    localparam int MAX_W        = 2048;
    localparam int LINES        = 4;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASE_PIXELS = 130;

    class blur_scoreboard;
        logic [sbr_pkg::WIDTH_REG_W-1:0]  width_reg;
        logic [sbr_pkg::HEIGHT_REG_W-1:0] height_reg;
        sbr_pkg::t_pix                    line_mem [LINES*MAX_W];
        sbr_pkg::t_pix                    window [4];
        int unsigned                      stream_pos;
        sbr_pkg::t_result                 expected_pixels [$];
        int                               errors;
        int                               checked;

        function new();
            width_reg  = sbr_pkg::FRAME_WIDTH_RST;
            height_reg = sbr_pkg::FRAME_HEIGHT_RST;
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (window[i]) window[i] = '0;
            stream_pos = 0;
            errors     = 0;
            checked    = 0;
        endfunction

        function int unsigned cols();
            int unsigned w;
            w = (width_reg == 0) ? 1 : width_reg;
            return (w > MAX_W) ? MAX_W : w;
        endfunction

        function int unsigned rows();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function void write_reg(logic [sbr_pkg::CFG_INDEX_W-1:0] idx,
                                logic [sbr_pkg::CFG_DATA_W-1:0] data);
            if (idx == sbr_pkg::REG_FRAME_WIDTH) begin
                width_reg = data[sbr_pkg::WIDTH_REG_W-1:0];
            end else begin
                height_reg = data[sbr_pkg::HEIGHT_REG_W-1:0];
            end
        endfunction

        // 1-2-4-2-1 per channel, truncated divide by ten
        function sbr_pkg::t_pix blur5(sbr_pkg::t_pix a, sbr_pkg::t_pix b, sbr_pkg::t_pix c,
                                      sbr_pkg::t_pix d, sbr_pkg::t_pix e);
            sbr_pkg::t_pix res;
            int            s;
            int            k;
            for (k = 0; k < sbr_pkg::NUM_CH; k++) begin
                s = a[k] + 2 * b[k] + 4 * c[k] + 2 * d[k] + e[k];
                res[k] = sbr_pkg::CH_W'(s / 10);
            end
            return res;
        endfunction

        function void predict_pixel(sbr_pkg::t_pix pix, logic fill);
            int unsigned      w, h, area, lag, t, p, q, r, c, irow, icol;
            sbr_pkg::t_pix    cur, hval, v;
            bit               have_h;
            sbr_pkg::t_result res;
            w      = cols();
            h      = rows();
            area   = w * h;
            lag    = 2 * w + 2;
            t      = stream_pos;
            cur    = fill ? '0 : pix;
            have_h = 1'b0;
            hval   = '0;
            irow   = 0;
            icol   = 0;
            // horizontal pass on the pixel two beats back
            if (t >= 2 && t - 2 < area) begin
                p      = t - 2;
                irow   = p / w;
                icol   = p % w;
                have_h = 1'b1;
                if (w >= 5 && icol >= 2 && icol <= w - 3) begin
                    hval = blur5(window[3], window[2], window[1], window[0], cur);
                end else begin
                    hval = window[1];
                end
            end
            // vertical pass and output
            if (t >= lag && t - lag < area) begin
                q = t - lag;
                r = q / w;
                c = q % w;
                if (h >= 5 && r >= 2 && r <= h - 3 && have_h) begin
                    v = blur5(line_mem[((r - 2) % LINES) * MAX_W + c],
                              line_mem[((r - 1) % LINES) * MAX_W + c],
                              line_mem[(r % LINES) * MAX_W + c],
                              line_mem[((r + 1) % LINES) * MAX_W + c],
                              hval);
                end else begin
                    v = line_mem[(r % LINES) * MAX_W + c];
                end
                res.pix       = v;
                res.frame_end = (q == area - 1);
                expected_pixels.push_back(res);
            end
            if (have_h) begin
                line_mem[(irow % LINES) * MAX_W + icol] = hval;
            end
            window[3] = window[2];
            window[2] = window[1];
            window[1] = window[0];
            window[0] = cur;
            stream_pos = (t + 1 >= area + lag) ? 0 : t + 1;
        endfunction

        function void check_pixel(sbr_pkg::t_result got);
            sbr_pkg::t_result want;
            int               k;
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: output beat with nothing expected: a=%0d b=%0d c=%0d end=%0d",
                         $time, got.pix[0], got.pix[1], got.pix[2], got.frame_end);
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            for (k = 0; k < sbr_pkg::NUM_CH; k++) begin
                if (got.pix[k] !== want.pix[k]) begin
                    errors++;
                    $display("%0t: channel %0d mismatch: expected %0d, actual %0d",
                             $time, k, want.pix[k], got.pix[k]);
                end
            end
            if (got.frame_end !== want.frame_end) begin
                errors++;
                $display("%0t: frame_end mismatch: expected %0d, actual %0d",
                         $time, want.frame_end, got.frame_end);
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [sbr_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [sbr_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [sbr_pkg::CH_W-1:0]        i_chan_a_in;
    logic [sbr_pkg::CH_W-1:0]        i_chan_b_in;
    logic [sbr_pkg::CH_W-1:0]        i_chan_c_in;
    logic                            i_filler;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [sbr_pkg::CH_W-1:0]        o_chan_a_out;
    logic [sbr_pkg::CH_W-1:0]        o_chan_b_out;
    logic [sbr_pkg::CH_W-1:0]        o_chan_c_out;
    logic                            o_frame_end;

    blur_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    bit             hold_request;
    int             hold_left;
    int             quiet_cycles;
    int             pixels_sent;
    int             frames_sent;
    int             beats_sent;

    separable_blur_5x5_rgb #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_chan_a_in  (i_chan_a_in),
        .i_chan_b_in  (i_chan_b_in),
        .i_chan_c_in  (i_chan_c_in),
        .i_filler     (i_filler),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_chan_a_out (o_chan_a_out),
        .o_chan_b_out (o_chan_b_out),
        .o_chan_c_out (o_chan_c_out),
        .o_frame_end  (o_frame_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.predict_pixel({i_chan_c_in, i_chan_b_in, i_chan_a_in}, i_filler);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_pixel({o_frame_end, o_chan_c_out, o_chan_b_out, o_chan_a_out});
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
                $display("[separable_blur_5x5_rgb] ERROR");
                $finish;
            end
        end
    end

    function automatic sbr_pkg::t_chan rand_chan();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return sbr_pkg::t_chan'($urandom);
        endcase
    endfunction

    task automatic send_item(sbr_pkg::t_chan a, sbr_pkg::t_chan b, sbr_pkg::t_chan c,
                             logic fill);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_chan_a_in = a;
        i_chan_b_in = b;
        i_chan_c_in = c;
        i_filler    = fill;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        beats_sent++;
    endtask

    // flush beats: mostly fillers, some pixels past the frame end
    task automatic send_flush();
        int unsigned n;
        n = 2 * sb.cols() + 2;
        repeat (n) send_item(rand_chan(), rand_chan(), rand_chan(), ($urandom_range(7) != 0));
    endtask

    task automatic send_frame(int noise_pct);
        int unsigned area;
        area = sb.cols() * sb.rows();
        repeat (area) begin
            send_item(rand_chan(), rand_chan(), rand_chan(), ($urandom_range(99) < noise_pct));
        end
        pixels_sent += area;
        frames_sent++;
        send_flush();
    endtask

    // wait for the block to drain, then write both size registers
    task automatic set_frame(logic [sbr_pkg::CFG_DATA_W-1:0] wdata,
                             logic [sbr_pkg::CFG_DATA_W-1:0] hdata);
        i_in_valid = 1'b0;
        while (sb.expected_pixels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = sbr_pkg::REG_FRAME_WIDTH;
        i_cfg_data  = wdata;
        @(negedge i_clk);
        i_cfg_index = sbr_pkg::REG_FRAME_HEIGHT;
        i_cfg_data  = hdata;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.write_reg(sbr_pkg::REG_FRAME_WIDTH, wdata);
        sb.write_reg(sbr_pkg::REG_FRAME_HEIGHT, hdata);
    endtask

    initial begin
        int          phase_start;
        int unsigned w, h;
        sb             = new();
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = sbr_pkg::REG_FRAME_WIDTH;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_chan_a_in    = '0;
        i_chan_b_in    = '0;
        i_chan_c_in    = '0;
        i_filler       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        pixels_sent    = 0;
        frames_sent    = 0;
        beats_sent     = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // zero sizes act as a single pixel
        set_frame('0, '0);
        send_item(8'd255, 8'd0, 8'd170, 1'b0);
        send_item(8'd255, 8'd255, 8'd255, 1'b1);
        send_item(8'd1, 8'd128, 8'd254, 1'b0);
        send_item(8'd0, 8'd0, 8'd0, 1'b1);
        send_item(8'd255, 8'd255, 8'd255, 1'b1);

        // one row of five: full-scale sums and a filler inside the frame
        set_frame(13'd5, 13'd1);
        send_item(8'd0, 8'd255, 8'd0, 1'b0);
        send_item(8'd255, 8'd255, 8'd1, 1'b0);
        send_item(8'd0, 8'd255, 8'd254, 1'b0);
        send_item(8'd255, 8'd255, 8'd255, 1'b1);
        send_item(8'd255, 8'd255, 8'd255, 1'b0);
        send_flush();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 47;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 47;
                end
                default: begin
                    send_idle_pct  = 16;
                    recv_stall_pct = 16;
                end
            endcase
            if (ph == 0) begin
                // wide row, tall column, then a backed-up frame
                set_frame(13'd100, 13'd1);
                send_frame(3);
                set_frame(13'd1, 13'd300);
                send_frame(3);
                set_frame(13'd16, 13'd16);
                hold_request = 1'b1;
                send_frame(3);
            end
            phase_start = pixels_sent;
            while (pixels_sent - phase_start < PHASE_PIXELS) begin
                if ($urandom_range(2) != 0) begin
                    if ($urandom_range(5) == 0) begin
                        w = $urandom_range(5, 24);
                        h = $urandom_range(5, 12);
                    end else begin
                        w = $urandom_range(0, 9);
                        h = $urandom_range(0, 9);
                    end
                    set_frame({1'($urandom_range(1)), sbr_pkg::WIDTH_REG_W'(w)},
                              sbr_pkg::HEIGHT_REG_W'(h));
                end
                send_frame($urandom_range(0, 10));
            end
        end

        i_in_valid = 1'b0;
        while (sb.expected_pixels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("%0d random frames, %0d pixel beats, %0d beats in all, %0d pixels checked",
                 frames_sent, pixels_sent, beats_sent, sb.checked);
        $display("sizes from 1x1 up to 100 wide and 300 tall, four idle and stall mixes");
        if (sb.errors == 0) begin
            $display("[separable_blur_5x5_rgb] OK");
        end else begin
            $display("[separable_blur_5x5_rgb] ERROR");
        end
        $finish;
    end

endmodule
